// ----- rtl/core/sprk_pkg.sv -----
// ============================================================================
// sprk_pkg
// Shared types, register indexes and arithmetic helpers for the spark ring.
// ============================================================================
package sprk_pkg;

    localparam int Capacity = 64;
    localparam int SlotW    = $clog2(Capacity);
    localparam int CountW   = $clog2(Capacity + 1);
    localparam logic [16:0] C97 = 17'd63570;

    typedef enum logic [1:0] {
        REG_FRICTION = 2'd0,
        REG_BOUNCE   = 2'd1,
        REG_GRAVITY  = 2'd2,
        REG_LIFETIME = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                op;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [31:0]  vel_x;
        logic signed [31:0]  vel_y;
        logic signed [31:0]  vel_z;
        logic [30:0]         spread;
        logic [14:0]         rand_x;
        logic [14:0]         rand_y;
        logic [14:0]         rand_z;
        logic signed [31:0]  ground_level;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] head_x;
        logic signed [31:0] head_y;
        logic signed [31:0] head_z;
        logic signed [31:0] tail_x;
        logic signed [31:0] tail_y;
        logic signed [31:0] tail_z;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [3:0]         wr_idx;
        logic [31:0]        wr_data;
    } t_cfg_item;

    // Spark record as held in the memory.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] fl;
        logic [7:0]         timer;
    } t_spark;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Signed 32 by unsigned 17 Q16.16 multiply, floor shift and saturate.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic [16:0] b);
        logic signed [49:0] prod;
        prod = 50'(a) * $signed({1'b0, b});
        return sat32(50'(prod >>> 16));
    endfunction

endpackage

// ----- rtl/core/sprk_if.sv -----
// ============================================================================
// sprk_if
// Valid/ready channel carrying one payload of a given type.
// ============================================================================
interface sprk_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/sprk_mem.sv -----
// ============================================================================
// sprk_mem
// Spark record store: one write port, one registered read port.
// ============================================================================
module sprk_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [sprk_pkg::SlotW-1:0]  i_waddr,
    input  sprk_pkg::t_spark            i_wdata,
    input  logic [sprk_pkg::SlotW-1:0]  i_raddr,
    output sprk_pkg::t_spark            o_rdata
);
    sprk_pkg::t_spark r_mem [sprk_pkg::Capacity];
    sprk_pkg::t_spark r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/spark_particle_ring_update_core.sv -----
// ============================================================================
// spark_particle_ring_update_core
// Ring of sparks with spawn and tick requests, state held in one memory.
// ============================================================================
// Usage: requests enter on in_ch; op 0 spawns a spark, op 1 advances all
// live sparks by one tick. A spawn keeps the block busy and gives no
// result. A tick reads each spark from memory, runs it through a
// multiply sequence (one 32x17 multiply per cycle, nine multiply steps) and
// writes it back, giving one result per live spark on out_ch, with last set
// on the final one. Each spark passes through a read state, the compute
// steps and an emit state. Requests are taken one at a time. When the
// receiver stalls, the finished result waits in the output register and
// the sequencer holds. Configuration writes on cfg_ch are taken at any
// time and must come only while the block is idle. Reset restores the
// default registers and empties the ring; the memory itself is not
// cleared, since only written slots are ever read.
// ============================================================================
module spark_particle_ring_update_core (
    input  logic i_clk,
    input  logic i_rst_n,
    sprk_if.sink   in_ch,
    sprk_if.source out_ch,
    sprk_if.sink   cfg_ch
);
    localparam int SW = sprk_pkg::SlotW;
    localparam int CW = sprk_pkg::CountW;

    typedef enum logic [2:0] {
        S_IDLE, S_SPAWN, S_READ, S_CALC, S_EMIT
    } t_state;

    t_state r_state;
    logic [16:0] r_friction, r_bounce, r_gravity;
    logic [7:0]  r_lifetime;
    logic [SW-1:0] r_oldest, r_slot;
    logic [CW-1:0] r_count, r_k;
    logic          r_any_dead;
    logic [CW-1:0] r_dead_off;
    sprk_pkg::t_in_item r_req;
    logic [3:0] r_step;
    logic signed [31:0] r_vx, r_vy, r_vz, r_px, r_py, r_pz, r_fl;
    logic signed [31:0] r_tx, r_ty, r_tz, r_tmp;
    logic [7:0]  r_timer;
    logic        r_ovalid;
    sprk_pkg::t_out_item r_out;

    logic mem_we;
    logic [SW-1:0] mem_waddr;
    sprk_pkg::t_spark mem_wdata, mem_rdata;

    sprk_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_slot),
        .o_rdata (mem_rdata)
    );

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    // Shared multiplier: operand picked by step.
    logic signed [31:0] mul_a;
    logic [16:0]        mul_b;
    logic signed [31:0] mul_q;
    logic signed [32:0] vy_abs;
    always_comb begin
        vy_abs = (r_vy < 0) ? -33'(r_vy) : 33'(r_vy);
        mul_a = r_vx;
        mul_b = r_friction;
        unique case (r_step)
            4'd0: mul_a = r_vx;
            4'd1: mul_a = r_vy;
            4'd2: mul_a = r_vz;
            4'd3: mul_a = r_vx;
            4'd4: mul_a = r_vy;
            4'd5: mul_a = r_vz;
            4'd6: begin mul_a = r_tx; mul_b = sprk_pkg::C97; end
            4'd7: begin mul_a = r_ty; mul_b = sprk_pkg::C97; end
            4'd8: begin mul_a = r_tz; mul_b = sprk_pkg::C97; end
            default: mul_a = r_vx;
        endcase
        mul_q = sprk_pkg::qmul(mul_a, mul_b);
    end

    // Bounce product uses |vy| which may reach 2^31.
    logic signed [49:0] bnc_prod;
    logic signed [31:0] bnc_q;
    always_comb begin
        bnc_prod = 50'($signed(vy_abs)) * $signed({1'b0, r_bounce});
        bnc_q    = sprk_pkg::sat32(50'(bnc_prod >>> 16));
    end

    // Spawn jitter, one axis at a time across steps.
    logic [14:0] jr;
    logic signed [31:0] jbase;
    logic [46:0] jprod;
    logic signed [31:0] jvel;
    always_comb begin
        unique case (r_step)
            4'd0: begin jr = r_req.rand_x; jbase = r_req.vel_x; end
            4'd1: begin jr = r_req.rand_y; jbase = r_req.vel_y; end
            default: begin jr = r_req.rand_z; jbase = r_req.vel_z; end
        endcase
        jprod = 47'(r_req.spread) * 47'({jr, 1'b0});
        jvel  = sprk_pkg::sat32(50'(jbase) + 50'(jprod[46:15]) - 50'(r_req.spread));
    end

    // On a full ring the new spark takes the slot of the oldest one.
    logic [SW-1:0] spawn_slot;
    logic [CW-1:0] tmpc;
    always_comb begin
        tmpc = (r_count >= CW'(sprk_pkg::Capacity)) ? '0 : r_count;
        spawn_slot = SW'((CW+1)'(r_oldest) + (CW+1)'(tmpc)) ;
        if ((CW+1)'(r_oldest) + (CW+1)'(tmpc) >= (CW+1)'(sprk_pkg::Capacity)) begin
            spawn_slot = SW'((CW+1)'(r_oldest) + (CW+1)'(tmpc)
                - (CW+1)'(sprk_pkg::Capacity));
        end
    end

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
        return (s == SW'(sprk_pkg::Capacity - 1)) ? '0 : s + 1'b1;
    endfunction

    logic [SW-1:0] new_oldest;
    logic [CW:0]   oadd;
    always_comb begin
        oadd = (CW+1)'(r_oldest) + (CW+1)'(r_dead_off) + 1'b1;
        if (oadd >= (CW+1)'(sprk_pkg::Capacity)) begin
            oadd = oadd - (CW+1)'(sprk_pkg::Capacity);
        end
        new_oldest = SW'(oadd);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = '{px: r_px, py: r_py, pz: r_pz, vx: r_vx, vy: r_vy,
                      vz: r_vz, fl: r_fl, timer: r_timer};
        if (r_state == S_SPAWN && r_step == 4'd3) begin
            mem_we = 1'b1;
        end else if (r_state == S_CALC && r_step == 4'd12) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_friction <= 17'd64225;
            r_bounce   <= 17'd45875;
            r_gravity  <= 17'd5243;
            r_lifetime <= 8'd80;
            r_oldest   <= '0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_step     <= '0;
            r_slot     <= '0;
            r_k        <= '0;
            r_any_dead <= 1'b0;
            r_dead_off <= '0;
        end else begin
            if (cfg_ch.valid) begin
                unique case (cfg_ch.data.wr_idx)
                    4'(sprk_pkg::REG_FRICTION): r_friction <= cfg_ch.data.wr_data[16:0];
                    4'(sprk_pkg::REG_BOUNCE):   r_bounce   <= cfg_ch.data.wr_data[16:0];
                    4'(sprk_pkg::REG_GRAVITY):  r_gravity  <= cfg_ch.data.wr_data[16:0];
                    4'(sprk_pkg::REG_LIFETIME): r_lifetime <= cfg_ch.data.wr_data[7:0];
                    default: ;
                endcase
            end
            // In S_EMIT the output register is reloaded below instead.
            if (r_ovalid && out_ch.ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_req  <= in_ch.data;
                        r_step <= '0;
                        if (!in_ch.data.op) begin
                            r_state <= S_SPAWN;
                        end else if (r_count != '0) begin
                            r_slot     <= r_oldest;
                            r_k        <= '0;
                            r_any_dead <= 1'b0;
                            r_state    <= S_READ;
                        end
                    end
                end
                S_SPAWN: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step)
                        4'd0: r_vx <= jvel;
                        4'd1: r_vy <= jvel;
                        4'd2: begin
                            r_vz    <= jvel;
                            r_px    <= r_req.pos_x;
                            r_py    <= r_req.pos_y;
                            r_pz    <= r_req.pos_z;
                            r_fl    <= r_req.ground_level;
                            r_timer <= r_lifetime;
                            r_slot  <= spawn_slot;
                        end
                        default: begin
                            if (r_count >= CW'(sprk_pkg::Capacity)) begin
                                r_oldest <= nxt(r_oldest);
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_READ: begin
                    r_step  <= '0;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    unique case (r_step)
                        4'd0: begin
                            r_vx <= mem_rdata.vx; r_vy <= mem_rdata.vy;
                            r_vz <= mem_rdata.vz; r_px <= mem_rdata.px;
                            r_py <= mem_rdata.py; r_pz <= mem_rdata.pz;
                            r_fl <= mem_rdata.fl; r_timer <= mem_rdata.timer;
                        end
                        4'd1: begin
                            r_tx <= 0;
                        end
                        default: ;
                    endcase
                    // Step s in 1..8 uses multiplier index s; step 13 takes the default operand r_vx.
                    if (r_step == 4'd0) begin
                        r_step <= 4'd13;
                    end
                    if (r_step == 4'd13) begin
                        r_vx <= mul_q; r_step <= 4'd1;
                    end
                    if (r_step == 4'd1) begin
                        r_tmp <= mul_q;
                        r_step <= 4'd14;
                    end
                    if (r_step == 4'd14) begin
                        r_vy <= sprk_pkg::sat32(50'(r_tmp) - 50'(r_gravity));
                        r_step <= 4'd2;
                    end
                    if (r_step == 4'd2) begin
                        r_vz <= mul_q;
                        r_step <= 4'd15;
                    end
                    if (r_step == 4'd15) begin
                        r_px <= sprk_pkg::sat32(50'(r_px) + 50'(r_vx));
                        r_py <= sprk_pkg::sat32(50'(r_py) + 50'(r_vy));
                        r_pz <= sprk_pkg::sat32(50'(r_pz) + 50'(r_vz));
                        r_step <= 4'd10;
                    end
                    if (r_step == 4'd10) begin
                        if (r_py < r_fl) begin
                            r_py <= r_fl;
                            r_vy <= bnc_q;
                        end
                        r_step <= 4'd3;
                    end
                    if (r_step == 4'd3) begin
                        r_tx <= mul_q; r_step <= 4'd4;
                    end
                    if (r_step == 4'd4) begin
                        r_ty <= mul_q; r_step <= 4'd5;
                    end
                    if (r_step == 4'd5) begin
                        r_tz <= mul_q; r_step <= 4'd6;
                    end
                    if (r_step == 4'd6) begin
                        r_tx <= mul_q; r_step <= 4'd7;
                    end
                    if (r_step == 4'd7) begin
                        r_ty <= sprk_pkg::sat32(50'(mul_q) - 50'(r_gravity));
                        r_step <= 4'd8;
                    end
                    if (r_step == 4'd8) begin
                        r_tz <= mul_q;
                        r_tx <= sprk_pkg::sat32(50'(r_px) + 50'(r_tx));
                        r_ty <= sprk_pkg::sat32(50'(r_py) + 50'(r_ty));
                        r_step <= 4'd11;
                    end
                    if (r_step == 4'd11) begin
                        r_tz <= sprk_pkg::sat32(50'(r_pz) + 50'(r_tz));
                        if (r_ty < r_fl) begin
                            r_ty <= r_fl;
                        end
                        if (r_timer <= 8'd1) begin
                            r_timer    <= 8'd0;
                            r_any_dead <= 1'b1;
                            r_dead_off <= r_k;
                        end else begin
                            r_timer <= r_timer - 1'b1;
                        end
                        r_step <= 4'd12;
                    end
                    if (r_step == 4'd12) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || out_ch.ready) begin
                        r_ovalid <= 1'b1;
                        r_out    <= '{head_x: r_px, head_y: r_py, head_z: r_pz,
                                      tail_x: r_tx, tail_y: r_ty, tail_z: r_tz,
                                      last: (r_k + 1'b1 == r_count)};
                        if (r_k + 1'b1 == r_count) begin
                            if (r_any_dead) begin
                                r_oldest <= new_oldest;
                                r_count  <= r_count - r_dead_off - 1'b1;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_slot  <= nxt(r_slot);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
